// ===== rtl/core/rfc_pkg.sv =====
package rfc_pkg;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_RECT    = 2'd0,
    KIND_ELLIPSE = 2'd1,
    KIND_COPY    = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  // Pixel word width
  localparam int unsigned PIX_W = 32;

  // Signed coordinate width: covers -511 .. 766 for every command kind
  localparam int unsigned COORD_W = 11;

  // Ellipse accumulator width: x^2*ry^2 + y^2*rx^2 stays below 2^36
  localparam int unsigned ELL_W = 38;

  // Command request
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       pos_x;
    logic [6:0]       pos_y;
    logic [8:0]       size_x;
    logic [7:0]       size_y;
    logic [7:0]       src_x;
    logic [6:0]       src_y;
    logic [PIX_W-1:0] color;
  } req_t;

  // Command result
  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             clipped;
  } rsp_t;

  // Pixel store port controls
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== rtl/core/rfc_store.sv =====
module rfc_store #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rfc_pkg::mem_ctl_t        ctl_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [rfc_pkg::PIX_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [rfc_pkg::PIX_W-1:0] rdata_o
);
  import rfc_pkg::*;

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] fwd_data_q;
  logic             fwd_q;

  // Single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rd_q       <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // Same-cycle write to the address being read: pass the new word through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ctl_i.re) begin
      fwd_q <= ctl_i.we && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/core/rfc_seq.sv =====
module rfc_seq #(
  parameter int unsigned STORE_WIDTH  = 256,
  parameter int unsigned STORE_HEIGHT = 128,
  parameter int unsigned AW           = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  rfc_pkg::req_t             req_i,
  output logic                      idle_o,
  output logic                      done_o,
  input  logic                      ready_i,
  output rfc_pkg::rsp_t             rsp_o,
  output rfc_pkg::mem_ctl_t         mem_ctl_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [rfc_pkg::PIX_W-1:0] mem_wdata_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [rfc_pkg::PIX_W-1:0] mem_rdata_i
);
  import rfc_pkg::*;

  // Row base address width: signed row times store width
  localparam int unsigned WSW = $clog2(STORE_WIDTH + 1) + 1;
  localparam int unsigned BW  = COORD_W + WSW;

  localparam logic [COORD_W:0]       W_LIM  = (COORD_W + 1)'(STORE_WIDTH);
  localparam logic [COORD_W:0]       H_LIM  = (COORD_W + 1)'(STORE_HEIGHT);
  localparam logic signed [16:0]     W_MUL  = 17'(STORE_WIDTH);
  localparam logic signed [BW-1:0]   W_STEP = BW'(STORE_WIDTH);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Setup steps on the shared multiplier
  localparam logic [2:0] SP_DBASE = 3'd0;
  localparam logic [2:0] SP_SBASE = 3'd1;
  localparam logic [2:0] SP_RX2   = 3'd1;
  localparam logic [2:0] SP_RY2   = 3'd2;
  localparam logic [2:0] SP_LIM   = 3'd3;
  localparam logic [2:0] SP_PX    = 3'd4;
  localparam logic [2:0] SP_QY    = 3'd5;
  localparam logic [2:0] SP_INIT  = 3'd6;

  logic [2:0] state_q;
  logic [2:0] step_q;
  logic       pend_q;

  kind_e                      kind_q;
  logic [PIX_W-1:0]           color_q;
  logic [8:0]                 rx_q;
  logic [7:0]                 ry_q;
  logic signed [COORD_W-1:0]  col_q, col0_q, col_end_q, row_q, row_end_q;
  logic signed [COORD_W-1:0]  scol_q, scol0_q, srow_q;
  logic signed [BW-1:0]       dbase_q, sbase_q;
  logic [17:0]                rx2_q;
  logic [15:0]                ry2_q;
  logic signed [ELL_W-1:0]    lim_q, a_q, b_q, d_q, e_q, dinit_q;
  logic [AW-1:0]              pend_addr_q;
  logic                       clip_q;
  logic [PIX_W-1:0]           rdata_q;

  logic signed [18:0]         mul_a;
  logic signed [16:0]         mul_b;
  logic signed [35:0]         prod;
  logic signed [BW-1:0]       dst_full, src_full;
  logic [AW-1:0]              dst_addr, src_addr;
  logic signed [ELL_W-1:0]    ell_sum;
  logic                       in_ell, dst_in, src_in, both_in;
  logic                       last_col, last_row, setup_last, empty, run, wr_pix;
  logic                       is_rect, is_ell, is_copy, is_read;

  function automatic logic in_store(logic signed [COORD_W-1:0] c,
                                    logic signed [COORD_W-1:0] r);
    logic ok;
    ok = !c[COORD_W-1] && !r[COORD_W-1] &&
         ({1'b0, c} < W_LIM) && ({1'b0, r} < H_LIM);
    return ok;
  endfunction

  assign is_rect = (kind_q == KIND_RECT);
  assign is_ell  = (kind_q == KIND_ELLIPSE);
  assign is_copy = (kind_q == KIND_COPY);
  assign is_read = (kind_q == KIND_READ);

  // Shared multiplier operand selection
  always_comb begin
    mul_a = 19'(row_q);
    mul_b = W_MUL;
    if (is_copy && (step_q == SP_SBASE)) begin
      mul_a = 19'(srow_q);
    end
    if (is_ell) begin
      case (step_q)
        SP_RX2: begin
          mul_a = {10'b0, rx_q};
          mul_b = {8'b0, rx_q};
        end
        SP_RY2: begin
          mul_a = {11'b0, ry_q};
          mul_b = {9'b0, ry_q};
        end
        SP_LIM: begin
          mul_a = {1'b0, rx2_q};
          mul_b = {1'b0, ry2_q};
        end
        SP_PX: begin
          mul_a = {10'b0, rx_q};
          mul_b = {1'b0, ry2_q};
        end
        SP_QY: begin
          mul_a = {1'b0, rx2_q};
          mul_b = {9'b0, ry_q};
        end
        default: begin
          mul_a = 19'(row_q);
          mul_b = W_MUL;
        end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  // Pixel addresses and tests
  assign dst_full = dbase_q + BW'(col_q);
  assign src_full = sbase_q + BW'(scol_q);
  assign dst_addr = dst_full[AW-1:0];
  assign src_addr = src_full[AW-1:0];
  assign dst_in   = in_store(col_q, row_q);
  assign src_in   = in_store(scol_q, srow_q);
  assign both_in  = dst_in && src_in;
  assign ell_sum  = a_q + b_q;
  assign in_ell   = (ell_sum <= lim_q);
  assign last_col = (col_q == col_end_q);
  assign last_row = (row_q == row_end_q);

  assign empty = ((req_i.kind == KIND_RECT) || (req_i.kind == KIND_COPY)) &&
                 ((req_i.size_x == '0) || (req_i.size_y == '0));

  always_comb begin
    case (kind_q)
      KIND_COPY:    setup_last = (step_q == SP_SBASE);
      KIND_ELLIPSE: setup_last = (step_q == SP_INIT);
      default:      setup_last = (step_q == SP_DBASE);
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SP_DBASE;
      pend_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          pend_q <= 1'b0;
          step_q <= SP_DBASE;
          if (start_i) begin
            state_q <= empty ? ST_DONE : ST_SETUP;
          end
        end
        ST_SETUP: begin
          step_q <= step_q + 3'd1;
          if (setup_last) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          pend_q <= is_copy && both_in;
          if (is_read) begin
            state_q <= ST_DRAIN;
          end else if (last_col && last_row) begin
            state_q <= is_copy ? ST_DRAIN : ST_DONE;
          end
        end
        ST_DRAIN: begin
          pend_q  <= 1'b0;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_q  <= req_i.kind;
          color_q <= req_i.color;
          rx_q    <= req_i.size_x;
          ry_q    <= req_i.size_y;
          clip_q  <= 1'b0;
          rdata_q <= '0;
          scol_q  <= COORD_W'(req_i.src_x);
          scol0_q <= COORD_W'(req_i.src_x);
          srow_q  <= COORD_W'(req_i.src_y);
          if (req_i.kind == KIND_ELLIPSE) begin
            col_q     <= COORD_W'(req_i.pos_x) - COORD_W'(req_i.size_x);
            col0_q    <= COORD_W'(req_i.pos_x) - COORD_W'(req_i.size_x);
            col_end_q <= COORD_W'(req_i.pos_x) + COORD_W'(req_i.size_x);
            row_q     <= COORD_W'(req_i.pos_y) - COORD_W'(req_i.size_y);
            row_end_q <= COORD_W'(req_i.pos_y) + COORD_W'(req_i.size_y);
          end else begin
            col_q     <= COORD_W'(req_i.pos_x);
            col0_q    <= COORD_W'(req_i.pos_x);
            col_end_q <= COORD_W'(req_i.pos_x) + COORD_W'(req_i.size_x)
                         - COORD_W'(1);
            row_q     <= COORD_W'(req_i.pos_y);
            row_end_q <= COORD_W'(req_i.pos_y) + COORD_W'(req_i.size_y)
                         - COORD_W'(1);
          end
        end
      end
      ST_SETUP: begin
        if (step_q == SP_DBASE) begin
          dbase_q <= prod[BW-1:0];
        end else if (is_copy) begin
          sbase_q <= prod[BW-1:0];
        end else begin
          // Ellipse constants and the incremental x^2*ry^2 / y^2*rx^2 terms
          case (step_q)
            SP_RX2: rx2_q   <= prod[17:0];
            SP_RY2: ry2_q   <= prod[15:0];
            SP_LIM: lim_q   <= ELL_W'(prod);
            SP_PX:  dinit_q <= ELL_W'(prod);
            SP_QY:  e_q     <= ELL_W'(prod);
            SP_INIT: begin
              dinit_q <= ELL_W'(ry2_q) - (dinit_q <<< 1);
              d_q     <= ELL_W'(ry2_q) - (dinit_q <<< 1);
              e_q     <= ELL_W'(rx2_q) - (e_q <<< 1);
              a_q     <= lim_q;
              b_q     <= lim_q;
            end
            default: lim_q <= lim_q;
          endcase
        end
      end
      ST_RUN: begin
        pend_addr_q <= dst_addr;
        // Clip flag for skipped pixels
        case (kind_q)
          KIND_RECT:    if (!dst_in) clip_q <= 1'b1;
          KIND_ELLIPSE: if (in_ell && !dst_in) clip_q <= 1'b1;
          KIND_COPY:    if (!both_in) clip_q <= 1'b1;
          default:      if (!dst_in) clip_q <= 1'b1;
        endcase
        // Raster walk
        if (last_col) begin
          col_q   <= col0_q;
          scol_q  <= scol0_q;
          row_q   <= row_q + COORD_W'(1);
          srow_q  <= srow_q + COORD_W'(1);
          dbase_q <= dbase_q + W_STEP;
          sbase_q <= sbase_q + W_STEP;
          a_q     <= lim_q;
          d_q     <= dinit_q;
          b_q     <= b_q + e_q;
          e_q     <= e_q + ELL_W'({rx2_q, 1'b0});
        end else begin
          col_q  <= col_q + COORD_W'(1);
          scol_q <= scol_q + COORD_W'(1);
          a_q    <= a_q + d_q;
          d_q    <= d_q + ELL_W'({ry2_q, 1'b0});
        end
      end
      ST_DRAIN: begin
        if (is_read && !clip_q) begin
          rdata_q <= mem_rdata_i;
        end
      end
      default: rdata_q <= rdata_q;
    endcase
  end

  // Store port: fills write directly, copies write in the cycle after the read
  assign run    = (state_q == ST_RUN);
  assign wr_pix = run && dst_in && (is_rect || (is_ell && in_ell));

  assign mem_ctl_o.we = pend_q || wr_pix;
  assign mem_ctl_o.re = run && ((is_copy && both_in) || (is_read && dst_in));
  assign mem_waddr_o  = pend_q ? pend_addr_q : dst_addr;
  assign mem_wdata_o  = pend_q ? mem_rdata_i : color_q;
  assign mem_raddr_o  = is_copy ? src_addr : dst_addr;

  assign idle_o          = (state_q == ST_IDLE);
  assign done_o          = (state_q == ST_DONE);
  assign rsp_o.read_data = rdata_q;
  assign rsp_o.clipped   = clip_q;

endmodule

// ===== rtl/core/raster_fill_and_copy_engine.sv =====
// Raster fill and copy engine: a STORE_WIDTH x STORE_HEIGHT store of 32-bit
// pixels, held in one synchronous RAM, with four commands: fill a rectangle,
// fill an ellipse, copy a rectangle (row order, so overlapping copies see
// their own earlier writes) and read one pixel. Every request gives one
// response; pixels outside the store are skipped and flagged as clipped.
// After reset the RAM is swept to zero, during which no request is taken.
// One request is worked on at a time, one pixel per cycle, bounded by the
// single RAM write port; setup runs on one shared multiplier, and a
// zero-sized rectangle or copy goes straight to its response. A request
// may be taken while the previous response still waits in the output
// register.
module raster_fill_and_copy_engine #(
  parameter int unsigned STORE_WIDTH  = 256,
  parameter int unsigned STORE_HEIGHT = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rfc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rfc_pkg::rsp_t out_rsp_o
);
  import rfc_pkg::*;

  localparam int unsigned DEPTH = STORE_WIDTH * STORE_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic             clr_q;
  logic [AW-1:0]    clr_addr_q;
  logic             out_valid_q;
  rsp_t             out_q;

  logic             start, seq_idle, seq_done, out_ready;
  rsp_t             seq_rsp;
  mem_ctl_t         seq_ctl, mem_ctl;
  logic [AW-1:0]    seq_waddr, seq_raddr, mem_waddr;
  logic [PIX_W-1:0] seq_wdata, mem_wdata, mem_rdata;

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  assign in_stall_o = clr_q || !seq_idle;
  assign start      = in_valid_i && !in_stall_o;

  // Store port: the sweep owns the write port while it runs
  assign mem_ctl.we = clr_q || seq_ctl.we;
  assign mem_ctl.re = seq_ctl.re;
  assign mem_waddr  = clr_q ? clr_addr_q : seq_waddr;
  assign mem_wdata  = clr_q ? '0 : seq_wdata;

  rfc_seq #(
    .STORE_WIDTH  (STORE_WIDTH),
    .STORE_HEIGHT (STORE_HEIGHT),
    .AW           (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (in_req_i),
    .idle_o      (seq_idle),
    .done_o      (seq_done),
    .ready_i     (out_ready),
    .rsp_o       (seq_rsp),
    .mem_ctl_o   (seq_ctl),
    .mem_waddr_o (seq_waddr),
    .mem_wdata_o (seq_wdata),
    .mem_raddr_o (seq_raddr),
    .mem_rdata_i (mem_rdata)
  );

  rfc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (seq_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done && out_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done && out_ready) begin
      out_q <= seq_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
